[src/assert_macros.svh]
// Assertion macros for the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/iprl_pkg.sv]
// Package for the IP range region lookup: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package iprl_pkg;
  localparam int TableDepthDefault = 64;
  localparam logic [31:0] ScanWindowReset = 32'h0100_0000;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [2:0] ST_CLEARED = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_MATCH = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [15:0] region_id;
    logic [31:0] query_addr;
  } cmd_t;
endpackage

[src/iprl_front.sv]
// Front end: input skid queue of two words between the port and the engine.
// Depends on iprl_pkg.
`timescale 1ns / 1ps
module iprl_front import iprl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_take,
  output cmd_t q_cmd
);
  cmd_t slot [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign pop = q_valid && q_take;
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[src/iprl_back.sv]
// Back end: sorted table in memories, insert shift and backward query scan.
// Depends on iprl_pkg.
`timescale 1ns / 1ps
module iprl_back import iprl_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] scan_window,
  input  logic        q_valid,
  output logic        q_take,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_region
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_WRITE = 6'b001000,
    S_SCAN  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  logic [31:0] mem_s [TABLE_DEPTH];
  logic [31:0] mem_e [TABLE_DEPTH];
  logic [15:0] mem_r [TABLE_DEPTH];

  state_t      state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;          // entry being examined, plus one
  logic [31:0] rd_s;
  logic [31:0] rd_e;
  logic [15:0] rd_r;
  logic        rd_ok;          // registered read data belongs to idx
  cmd_t        cur;
  logic [31:0] bound;
  logic [2:0]  res_status;
  logic [15:0] res_region;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0] wr_s;
  logic [31:0] wr_e;
  logic [15:0] wr_r;
  logic [IW-1:0] rd_addr;

  assign q_take = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);
  assign out_status = res_status;
  assign out_region = res_region;
  assign rd_addr = IW'(idx - 1'b1);

  // One read and one write port per table.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_s[wr_addr] <= wr_s;
      mem_e[wr_addr] <= wr_e;
      mem_r[wr_addr] <= wr_r;
    end
    rd_s <= mem_s[rd_addr];
    rd_e <= mem_e[rd_addr];
    rd_r <= mem_r[rd_addr];
  end

  // Insert: walk down from the top moving entries with a larger start up one.
  // Query: walk down from the top; entries above the address are skipped.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = IW'(idx);
    wr_s = rd_s;
    wr_e = rd_e;
    wr_r = rd_r;
    if (state == S_SHIFT && rd_ok && rd_s > cur.range_start) begin
      wr_en = 1'b1;
    end else if (state == S_WRITE) begin
      wr_en = 1'b1;
      wr_s = cur.range_start;
      wr_e = cur.range_end;
      wr_r = cur.region_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_ok <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_ok <= 1'b0;
          if (q_valid) begin
            cur <= q_cmd;
            idx <= count;
            bound <= (q_cmd.query_addr >= scan_window) ?
                     q_cmd.query_addr - scan_window : 32'd0;
            res_region <= 16'd0;
            case (mode_t'(q_cmd.mode))
              MODE_CLEAR: begin
                count <= '0;
                res_status <= ST_CLEARED;
                state <= S_OUT;
              end
              MODE_INSERT: begin
                if (count >= DepthC) begin
                  res_status <= ST_FULL;
                  state <= S_OUT;
                end else begin
                  state <= (count == '0) ? S_WRITE : S_SHIFT;
                end
              end
              MODE_QUERY: begin
                res_status <= ST_NOMATCH;
                state <= (count == '0) ? S_OUT : S_SCAN;
              end
              default: begin
                res_status <= ST_NOMATCH;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SHIFT: begin
          // Read of idx-1 was issued last cycle; evaluate once it lands.
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else if (rd_s > cur.range_start) begin
            idx <= idx - 1'b1;
            rd_ok <= 1'b0;
            if (idx == CW'(1)) state <= S_WRITE;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          count <= count + 1'b1;
          res_status <= ST_INSERTED;
          state <= S_OUT;
        end
        S_SCAN: begin
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (rd_s > cur.query_addr) begin
              // Above the address: not yet at the search start.
              if (idx == CW'(1)) state <= S_OUT;
              idx <= idx - 1'b1;
            end else if (cur.query_addr <= rd_e) begin
              res_status <= ST_MATCH;
              res_region <= rd_r;
              state <= S_OUT;
            end else if (rd_s < bound || idx == CW'(1)) begin
              state <= S_OUT;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/ip_range_region_lookup_top.sv]
// Top level of the IP range region lookup: config register, front queue, back end.
// Depends on iprl_pkg, iprl_front, iprl_back and assert_macros.svh.
//
//  channel | signals                                           | flow
//  --------+---------------------------------------------------+------
//  in      | in_valid, in_stall, mode, range_start, range_end,  | in
//          | region_id, query_addr                             |
//  out     | out_valid, out_stall, status, match_region        | out
//  cfg     | cfg_we, cfg_wdata (scan_window)                   | in
//
// Clear, full drop and unused mode go straight to the result; insert moves each
// entry with a larger start up one, stops at the first start not larger and
// writes the new entry; query visits entries one at a time in the backward walk,
// through the single read port of the table memories.
// Reset empties the table and loads scan_window with 1 << 24.
// A two-word queue takes input words while the back end works or the output
// is stalled; the result register holds until taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ip_range_region_lookup_top import iprl_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  input  logic [15:0] region_id,
  input  logic [31:0] query_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] match_region
);
  logic [31:0] scan_window;
  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_window <= ScanWindowReset;
    end else if (cfg_we) begin
      scan_window <= cfg_wdata;
    end
  end

  assign in_cmd = '{mode: mode, range_start: range_start, range_end: range_end,
                    region_id: region_id, query_addr: query_addr};

  iprl_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  iprl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .scan_window(scan_window),
    .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(status), .out_region(match_region)
  );

  // Only a match carries a region.
  `ASSERT_IMPL(a_region_zero, clk, rst, out_valid && status != ST_MATCH,
               match_region == 16'd0, "region set without a match")
  // Status code stays in range.
  `ASSERT_IMPL(a_status_range, clk, rst, out_valid, status <= ST_NOMATCH,
               "bad status code")
  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
               out_valid && $stable(status) && $stable(match_region),
               "stalled result changed")
endmodule

[test/iprl_checker.sv]
// Checker for the IP range region lookup: watches the input, output and config ports,
// predicts each result word from its own copy of the range table and compares in order.
// Depends on iprl_pkg.
`timescale 1ns / 1ps
module iprl_checker import iprl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  input  logic [15:0] region_id,
  input  logic [31:0] query_addr,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [15:0] match_region,
  output int          fail_count,
  output int          pending
);
  localparam int Depth = TableDepthDefault;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] region;
  } answer_t;

  logic [31:0] lo_tab[Depth];
  logic [31:0] hi_tab[Depth];
  logic [15:0] reg_tab[Depth];
  int          used;
  logic [31:0] window;
  answer_t     answers[$];

  function automatic answer_t lookup(logic [31:0] addr);
    answer_t     a;
    int          idx;
    logic [31:0] floor_addr;
    a = '{status: ST_NOMATCH, region: 16'd0};
    floor_addr = (addr >= window) ? addr - window : 32'd0;
    idx = 0;
    while (idx < used && lo_tab[idx] <= addr) idx++;
    while (idx > 0) begin
      idx--;
      if (addr >= lo_tab[idx] && addr <= hi_tab[idx]) begin
        a.status = ST_MATCH;
        a.region = reg_tab[idx];
        return a;
      end
      if (lo_tab[idx] < floor_addr) break;
    end
    return a;
  endfunction

  function automatic logic [2:0] add_range(logic [31:0] s, logic [31:0] e, logic [15:0] r);
    int pos;
    if (used >= Depth) return ST_FULL;
    pos = used;
    while (pos > 0 && lo_tab[pos-1] > s) pos--;
    for (int k = used; k > pos; k--) begin
      lo_tab[k] = lo_tab[k-1];
      hi_tab[k] = hi_tab[k-1];
      reg_tab[k] = reg_tab[k-1];
    end
    lo_tab[pos] = s;
    hi_tab[pos] = e;
    reg_tab[pos] = r;
    used++;
    return ST_INSERTED;
  endfunction

  always @(posedge clk) begin
    answer_t a;
    answer_t exp_a;
    if (rst) begin
      used = 0;
      window = ScanWindowReset;
      answers.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) window = cfg_wdata;
      if (in_valid && !in_stall) begin
        a = '{status: ST_NOMATCH, region: 16'd0};
        case (mode_t'(mode))
          MODE_CLEAR: begin
            used = 0;
            a.status = ST_CLEARED;
          end
          MODE_INSERT: a.status = add_range(range_start, range_end, region_id);
          MODE_QUERY: a = lookup(query_addr);
          default: ;
        endcase
        answers.insert(answers.size(), a);
      end
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: status %0d region %0h", status, match_region);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = answers.pop_front();
          if (exp_a.status !== status || exp_a.region !== match_region) begin
            if (fail_count < 10)
              $display("mismatch: expected status %0d region %0h, got status %0d region %0h",
                       exp_a.status, exp_a.region, status, match_region);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= answers.size();
  end
endmodule

[test/tb_ip_range_region_lookup_top.sv]
// Testbench top for the IP range region lookup: clock, reset, stimulus and verdict.
// Depends on iprl_pkg, ip_range_region_lookup_top and iprl_checker.
`timescale 1ns / 1ps
module tb_ip_range_region_lookup_top;
  import iprl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_CLEAR;
  logic [31:0] range_start = '0;
  logic [31:0] range_end = '0;
  logic [15:0] region_id = '0;
  logic [31:0] query_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] match_region;
  int          fail_count;
  int          pending;

  // when set, both sides idle/stall at random; cleared for a clean stretch
  logic        jitter = 1'b1;
  logic [31:0] base;

  always #4 clk = ~clk;

  ip_range_region_lookup_top uut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .mode, .range_start,
    .range_end, .region_id, .query_addr, .out_valid, .out_stall, .status, .match_region
  );

  iprl_checker chk (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .mode, .range_start,
    .range_end, .region_id, .query_addr, .out_valid, .out_stall, .status, .match_region,
    .fail_count, .pending
  );

  // receiver back-pressure, stalled with probability 1/5 while jitter is on
  always @(posedge clk)
    out_stall <= jitter && ($urandom_range(99) < 20);

  // Present one word and hold it until taken. in_stall is read at the falling
  // edge, where it is settled, to decide whether the next rising edge accepts.
  task automatic send_word(mode_t m, logic [31:0] s, logic [31:0] e,
                           logic [15:0] r, logic [31:0] q);
    logic taken;
    while (jitter && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    range_start <= s;
    range_end <= e;
    region_id <= r;
    query_addr <= q;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // only between phases: drain, let the back end settle, then write the window
  task automatic set_window(logic [31:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] near(logic [31:0] b);
    return b + $urandom_range(0, 4095);
  endfunction

  // random phase: clustered ranges around base so queries actually hit
  task automatic run_phase(int items, int insert_pct);
    logic [31:0] s;
    logic [31:0] e;
    int          pick;
    send_word(MODE_CLEAR, $urandom, $urandom, 16'($urandom), $urandom);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      s = near(base);
      case ($urandom_range(9))
        0: e = s - $urandom_range(1, 64);          // inverted range, never matches, unless the subtraction wraps
        1: e = $urandom;
        default: e = s + $urandom_range(0, 600);
      endcase
      if (pick < insert_pct)
        send_word(MODE_INSERT, s, e, 16'($urandom), $urandom);
      else if (pick < 96)
        send_word(MODE_QUERY, $urandom, $urandom, 16'($urandom),
                  ($urandom_range(15) == 0) ? $urandom : near(base));
      else if (pick < 98)
        send_word(MODE_NONE, $urandom, $urandom, 16'($urandom), $urandom);
      else
        send_word(MODE_CLEAR, $urandom, $urandom, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, equal starts, inverted range, unused mode, clear
    send_word(MODE_QUERY, '0, '0, '0, 32'h0000_0000);
    send_word(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, '1);
    send_word(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, '0);
    send_word(MODE_INSERT, 32'h0000_1000, 32'h0000_10FF, 16'h00AA, '0);
    send_word(MODE_INSERT, 32'h0000_1000, 32'h0000_1FFF, 16'h00BB, '0);
    send_word(MODE_INSERT, 32'h0000_3000, 32'h0000_2000, 16'h00CC, '0);
    send_word(MODE_QUERY, '1, '1, '1, 32'h0000_1050);
    send_word(MODE_QUERY, '0, '0, '0, 32'h0000_1500);
    send_word(MODE_QUERY, '0, '0, '0, 32'h0000_2800);
    send_word(MODE_QUERY, '0, '0, '0, 32'hFFFF_FFFF);
    send_word(MODE_QUERY, '0, '0, '0, 32'h0000_0000);
    send_word(MODE_NONE, '1, '1, '1, '1);
    send_word(MODE_CLEAR, '1, '1, '1, '1);
    send_word(MODE_QUERY, '0, '0, '0, 32'h0000_1050);

    // window of zero: only the nearest starts are visited; then the widest window for the same query
    set_window(32'd0);
    send_word(MODE_INSERT, 32'h0000_0100, 32'h0000_0FFF, 16'h1234, '0);
    send_word(MODE_INSERT, 32'h0000_0800, 32'h0000_0810, 16'h5678, '0);
    send_word(MODE_QUERY, '0, '0, '0, 32'h0000_0900);
    set_window(32'hFFFF_FFFF);
    send_word(MODE_QUERY, '0, '0, '0, 32'h0000_0900);

    // sender holds off until every result is back
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    base = 32'h0000_0000;
    set_window(ScanWindowReset);
    run_phase(100, 45);
    base = $urandom;
    set_window(32'd0);
    run_phase(100, 45);
    // fill past full
    base = 32'hFFFF_F000;
    set_window(32'hFFFF_FFFF);
    run_phase(120, 90);
    base = $urandom;
    set_window($urandom_range(0, 2048));
    run_phase(100, 50);
    // clean stretch, no idling on either side
    jitter = 1'b0;
    base = $urandom;
    set_window($urandom_range(0, 512));
    run_phase(130, 50);
    jitter = 1'b1;
    for (int p = 0; p < 5; p++) begin
      base = $urandom;
      set_window(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 3000));
      run_phase(95, 45);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("ip_range_region_lookup_top test passed");
    else
      $display("ip_range_region_lookup_top test failed");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #(16_000_000);
    $display("ip_range_region_lookup_top test failed");
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/iprl_pkg.sv
src/iprl_front.sv
src/iprl_back.sv
src/ip_range_region_lookup_top.sv
test/iprl_checker.sv
test/tb_ip_range_region_lookup_top.sv
